FILE: design/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg: shared types and constants of the batched matrix multiply unit
// Payload structs, chain control, state encoding and configuration indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package bmm_pkg;

	localparam int DIM_DEFAULT = 16;
	localparam int DATA_W      = 16;
	localparam int ACC_W       = 36;
	localparam int REG_W       = 5;
	localparam int OIDX_W      = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int REG_RESET   = 16;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_STREAM = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LAYER_COUNT = 2'd0,
		CFG_ROW_COUNT   = 2'd1,
		CFG_INNER_SIZE  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_FLUSH,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic                     mode;
		logic signed [DATA_W-1:0] element;
	} item_t;

	typedef struct packed {
		logic [OIDX_W-1:0]       layer_index;
		logic [OIDX_W-1:0]       row_index;
		logic [OIDX_W-1:0]       column_index;
		logic signed [ACC_W-1:0] dot_value;
		logic                    row_last;
		logic                    batch_done;
	} result_t;

	// operand traveling down the cell chain
	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] a;
	} tok_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} chain_ctl_t;

	typedef struct packed {
		logic              valid;
		logic              row_last;
		logic              batch_done;
		logic [OIDX_W-1:0] layer;
		logic [OIDX_W-1:0] row;
		logic [OIDX_W-1:0] column;
	} emit_t;

endpackage

`default_nettype wire

FILE: design/bmm_cell.sv
// ----------------------------------------------------------------------------
// bmm_cell: one column accumulator of the cell chain
// Multiply-accumulates the passing operand, shifts toward cell zero on drain.
// ----------------------------------------------------------------------------
`default_nettype none

module bmm_cell (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire bmm_pkg::chain_ctl_t              chain,
	input  wire bmm_pkg::tok_t                    tok_in,
	input  wire logic signed [bmm_pkg::DATA_W-1:0] b,
	input  wire logic signed [bmm_pkg::ACC_W-1:0]  acc_in,
	output logic signed [bmm_pkg::ACC_W-1:0]       acc,
	output bmm_pkg::tok_t                          tok_out
);

	logic signed [2*bmm_pkg::DATA_W-1:0] prod;
	logic signed [bmm_pkg::ACC_W-1:0]    acc_q;
	logic                                tok_valid_q;
	logic signed [bmm_pkg::DATA_W-1:0]   tok_a_q;

	assign prod = $signed(tok_in.a) * b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			tok_valid_q <= 1'b0;
		end else begin
			if (chain.clear) begin
				acc_q <= '0;
			end else if (chain.shift) begin
				acc_q <= acc_in;
			end else if (tok_in.valid) begin
				acc_q <= acc_q + bmm_pkg::ACC_W'(prod);
			end
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_a_q <= tok_in.a;
	end

	assign acc             = acc_q;
	assign tok_out.valid   = tok_valid_q;
	assign tok_out.a       = tok_a_q;

endmodule

`default_nettype wire

FILE: design/bmm_ctrl.sv
// ----------------------------------------------------------------------------
// bmm_ctrl: sequencer of the batched matrix multiply unit
// Configuration, load and stream positions, store addressing and drain.
// ----------------------------------------------------------------------------
`default_nettype none

module bmm_ctrl #(
	parameter  int MAX_DIM = bmm_pkg::DIM_DEFAULT,
	localparam int IDX_W   = $clog2(MAX_DIM),
	localparam int LIM_W   = $clog2(MAX_DIM + 1),
	localparam int DEPTH   = MAX_DIM * MAX_DIM * MAX_DIM,
	localparam int AW      = $clog2(DEPTH)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire bmm_pkg::item_t                     item,
	input  wire logic                               cfg_write,
	input  wire logic [bmm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bmm_pkg::REG_W-1:0]          cfg_data,
	output logic                                    busy,
	output logic                                    mem_we,
	output logic [AW-1:0]                           mem_waddr,
	output logic [bmm_pkg::DATA_W-1:0]              mem_wdata,
	output logic [AW-1:0]                           mem_raddr,
	output logic                                    inject,
	output logic signed [bmm_pkg::DATA_W-1:0]       a_val,
	output logic [LIM_W-1:0]                        inner_lim,
	output bmm_pkg::chain_ctl_t                     chain,
	output bmm_pkg::emit_t                          emit
);

	bmm_pkg::state_t state_q, state_d;

	logic [bmm_pkg::REG_W-1:0] layer_count_q, row_count_q, inner_size_q;
	logic [LIM_W-1:0]          p_lim, q_lim, r_lim;

	logic [IDX_W-1:0] load_layer_q, load_row_q, load_col_q;
	logic [IDX_W-1:0] stream_layer_q, stream_row_q, stream_col_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] base_layer_q, base_x_q, out_layer_q, out_row_q;
	logic signed [bmm_pkg::DATA_W-1:0] a_q;
	logic row_end_q, done_q;
	logic accept, accept_stream, cnt_last;
	logic row_end, stream_row_wrap, stream_layer_wrap;

	function automatic logic [LIM_W-1:0] eff_dim(input logic [bmm_pkg::REG_W-1:0] v);
		logic [LIM_W-1:0] res;
		if (v == '0) begin
			res = LIM_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			res = LIM_W'(MAX_DIM);
		end else begin
			res = LIM_W'(v);
		end
		return res;
	endfunction

	function automatic logic wraps(input logic [IDX_W-1:0] ctr, input logic [LIM_W-1:0] lim);
		return (LIM_W'(ctr) + LIM_W'(1)) >= lim;
	endfunction

	function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] ctr,
			input logic [LIM_W-1:0] lim);
		return wraps(ctr, lim) ? '0 : ctr + IDX_W'(1);
	endfunction

	function automatic logic [AW-1:0] store_addr(input logic [IDX_W-1:0] l,
			input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
		return AW'(l) * AW'(MAX_DIM * MAX_DIM) + AW'(r) * AW'(MAX_DIM) + AW'(c);
	endfunction

	assign p_lim = eff_dim(layer_count_q);
	assign q_lim = eff_dim(row_count_q);
	assign r_lim = eff_dim(inner_size_q);

	assign cnt_last          = wraps(cnt_q, r_lim);
	assign row_end           = wraps(stream_col_q, r_lim);
	assign stream_row_wrap   = wraps(stream_row_q, q_lim);
	assign stream_layer_wrap = wraps(stream_layer_q, p_lim);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmm_pkg::ST_IDLE: begin
				if (start && item.mode == bmm_pkg::MODE_STREAM) state_d = bmm_pkg::ST_MAC;
			end
			bmm_pkg::ST_MAC: begin
				if (cnt_last) state_d = bmm_pkg::ST_FLUSH;
			end
			bmm_pkg::ST_FLUSH: begin
				state_d = row_end_q ? bmm_pkg::ST_DRAIN : bmm_pkg::ST_IDLE;
			end
			bmm_pkg::ST_DRAIN: begin
				if (cnt_last) state_d = bmm_pkg::ST_IDLE;
			end
			default: begin
				state_d = bmm_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy          = (state_q != bmm_pkg::ST_IDLE);
		accept        = start && (state_q == bmm_pkg::ST_IDLE);
		accept_stream = accept && (item.mode == bmm_pkg::MODE_STREAM);
		mem_we        = accept && (item.mode == bmm_pkg::MODE_LOAD);
		mem_waddr     = store_addr(load_layer_q, load_row_q, load_col_q);
		mem_wdata     = item.element;
		mem_raddr     = store_addr(base_layer_q, base_x_q, cnt_q);
		inject        = (state_q == bmm_pkg::ST_MAC) && (cnt_q == '0);
		a_val         = a_q;
		inner_lim     = r_lim;

		chain.shift   = (state_q == bmm_pkg::ST_DRAIN);
		chain.clear   = (state_q == bmm_pkg::ST_DRAIN) && cnt_last;

		emit.valid      = (state_q == bmm_pkg::ST_DRAIN);
		emit.row_last   = cnt_last;
		emit.batch_done = done_q && cnt_last;
		emit.layer      = bmm_pkg::OIDX_W'(out_layer_q);
		emit.row        = bmm_pkg::OIDX_W'(out_row_q);
		emit.column     = bmm_pkg::OIDX_W'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= bmm_pkg::ST_IDLE;
			layer_count_q  <= bmm_pkg::REG_W'(bmm_pkg::REG_RESET);
			row_count_q    <= bmm_pkg::REG_W'(bmm_pkg::REG_RESET);
			inner_size_q   <= bmm_pkg::REG_W'(bmm_pkg::REG_RESET);
			load_layer_q   <= '0;
			load_row_q     <= '0;
			load_col_q     <= '0;
			stream_layer_q <= '0;
			stream_row_q   <= '0;
			stream_col_q   <= '0;
			cnt_q          <= '0;
			row_end_q      <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_write) begin
				case (cfg_index)
					bmm_pkg::CFG_LAYER_COUNT: layer_count_q <= cfg_data;
					bmm_pkg::CFG_ROW_COUNT:   row_count_q   <= cfg_data;
					bmm_pkg::CFG_INNER_SIZE:  inner_size_q  <= cfg_data;
					default: ;
				endcase
			end

			if (mem_we) begin
				load_col_q <= bump(load_col_q, r_lim);
				if (wraps(load_col_q, r_lim)) begin
					load_row_q <= bump(load_row_q, r_lim);
					if (wraps(load_row_q, r_lim)) load_layer_q <= bump(load_layer_q, p_lim);
				end
			end

			if (accept_stream) begin
				row_end_q <= row_end;
				done_q    <= stream_row_wrap && stream_layer_wrap;
				if (row_end) begin
					stream_col_q <= '0;
					stream_row_q <= bump(stream_row_q, q_lim);
					if (stream_row_wrap) stream_layer_q <= bump(stream_layer_q, p_lim);
				end else begin
					stream_col_q <= stream_col_q + IDX_W'(1);
				end
			end

			// shared step counter: store column on mac, result column on drain
			if ((state_q == bmm_pkg::ST_MAC || state_q == bmm_pkg::ST_DRAIN) && !cnt_last) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_stream) begin
			a_q          <= item.element;
			base_layer_q <= stream_layer_q;
			base_x_q     <= stream_col_q;
			out_layer_q  <= stream_layer_q;
			out_row_q    <= stream_row_q;
		end
	end

endmodule

`default_nettype wire

FILE: design/batched_matrix_multiply_unit.sv
// Stream beat: busy after acceptance through the MAC state (one store read per inner
// column, one per cycle) and a flush state for the last cell; no new beat until idle.
// Row end: busy through a drain of the cell chain, one result per cycle, each result
// strobed in the cycle after its drain step; the single result port sets the pace.
// Load beat: written in the accepting cycle, busy stays low, one beat per cycle while idle.
// Reset: counters and accumulators cleared, registers to 16; store contents undefined.
// ----------------------------------------------------------------------------
// batched_matrix_multiply_unit: batched integer matrix multiply
// Second-operand store feeding a chain of column accumulator cells.
// ----------------------------------------------------------------------------
`default_nettype none

module batched_matrix_multiply_unit #(
	parameter  int MAX_DIM = bmm_pkg::DIM_DEFAULT,
	localparam int LIM_W   = $clog2(MAX_DIM + 1),
	localparam int DEPTH   = MAX_DIM * MAX_DIM * MAX_DIM,
	localparam int AW      = $clog2(DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire bmm_pkg::item_t                item,
	output logic                               busy,
	input  wire logic                          cfg_write,
	input  wire logic [bmm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bmm_pkg::REG_W-1:0]     cfg_data,
	output logic                               result_valid,
	output bmm_pkg::result_t                   result
);

	logic                              mem_we, inject, inj_s1;
	logic [AW-1:0]                     mem_waddr, mem_raddr;
	logic [bmm_pkg::DATA_W-1:0]        mem_wdata;
	logic signed [bmm_pkg::DATA_W-1:0] rd_data_s1;
	logic signed [bmm_pkg::DATA_W-1:0] a_val;
	logic [LIM_W-1:0]                  inner_lim;
	bmm_pkg::chain_ctl_t               chain;
	bmm_pkg::emit_t                    emit;

	logic [bmm_pkg::DATA_W-1:0] store [DEPTH];

	bmm_pkg::tok_t                    tok_in  [MAX_DIM];
	bmm_pkg::tok_t                    tok_out [MAX_DIM];
	logic signed [bmm_pkg::ACC_W-1:0] acc     [MAX_DIM];

	logic             result_valid_q;
	bmm_pkg::result_t result_q;

	bmm_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.inject    (inject),
		.a_val     (a_val),
		.inner_lim (inner_lim),
		.chain     (chain),
		.emit      (emit)
	);

	always_ff @(posedge clk) begin
		if (mem_we) store[mem_waddr] <= mem_wdata;
		rd_data_s1 <= store[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_s1 <= 1'b0;
		end else begin
			inj_s1 <= inject;
		end
	end

	// operand enters cell zero together with the first store word
	assign tok_in[0].valid = inj_s1;
	assign tok_in[0].a     = a_val;

	for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
		logic signed [bmm_pkg::ACC_W-1:0] acc_next;

		if (k < MAX_DIM - 1) begin : g_link
			assign acc_next            = acc[k+1];
			// operand stops past the last active column
			assign tok_in[k+1].valid   = tok_out[k].valid && (LIM_W'(k + 1) < inner_lim);
			assign tok_in[k+1].a       = tok_out[k].a;
		end else begin : g_end
			assign acc_next = '0;
		end

		bmm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.chain   (chain),
			.tok_in  (tok_in[k]),
			.b       (rd_data_s1),
			.acc_in  (acc_next),
			.acc     (acc[k]),
			.tok_out (tok_out[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.layer_index  <= emit.layer;
		result_q.row_index    <= emit.row;
		result_q.column_index <= emit.column;
		result_q.dot_value    <= acc[0];
		result_q.row_last     <= emit.row_last;
		result_q.batch_done   <= emit.batch_done;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a result beat only comes out of a drain
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result beat without a preceding drain");

	// operands never enter the chain while it shifts results out
	assert property (@(posedge clk) disable iff (!arst_n)
		inj_s1 |-> !chain.shift)
		else $error("operand injected during drain");

	// a row's last result is followed by a gap before the next row
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.row_last) |=> !result_valid)
		else $error("result beat right after end of row");

endmodule

`default_nettype wire
